[rtl/uv_sphere_vertex_generator_defines.svh]
// Assertion macros for the UV sphere vertex generator.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH
`define UV_SPHERE_VERTEX_GENERATOR_DEFINES_SVH

// Check that is suspended while reset is asserted.
`define USV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("usv assertion failed");

// Check that also holds across reset.
`define USV_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("usv assertion failed");

`endif

[rtl/usv_pkg.sv]
// Shared types, constants and the CORDIC arctangent table of the UV sphere
// vertex generator. No dependencies.
package usv_pkg;

  // Configuration register indexes.
  localparam logic REG_SECTOR_COUNT = 1'b0;
  localparam logic REG_STACK_COUNT  = 1'b1;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [31:0] CORDIC_GAIN_Q28 = 32'sd163008219;
  localparam logic signed [17:0] Q14_ONE = 18'sd16384;

  // Per-vertex side information that rides along the pipeline.
  typedef struct packed {
    logic [19:0] vidx;
    logic [19:0] nidx;
    logic [14:0] tex_s;
    logic [14:0] tex_t;
    logic        up;
    logic        lo;
  } meta_t;

  // CORDIC working state: x, y at scale 2^28, z in 2^32 per turn.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [33:0] z;
  } cord_t;

  // atan(2^-k) in units of 2^32 per full turn.
  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] v;
    unique case (k)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/usv_div.sv]
// A group of restoring division steps: one quotient bit per step.
// Depends on nothing; instanced twice per divider pipeline stage, once per index.
module usv_div #(
  parameter int NSTEP = 5
) (
  input  logic [9:0]  den,
  input  logic [9:0]  rem_in,
  input  logic [15:0] quo_in,
  output logic [9:0]  rem_out,
  output logic [15:0] quo_out
);

  // Shift the remainder left, subtract the divisor when it fits.
  always_comb begin
    logic [10:0] r2;
    logic [9:0]  rem;
    logic [15:0] quo;
    rem = rem_in;
    quo = quo_in;
    for (int s = 0; s < NSTEP; s++) begin
      r2 = {rem, 1'b0};
      if (r2 >= {1'b0, den}) begin
        rem = 10'(r2 - {1'b0, den});
        quo = {quo[14:0], 1'b1};
      end else begin
        rem = r2[9:0];
        quo = {quo[14:0], 1'b0};
      end
    end
    rem_out = rem;
    quo_out = quo;
  end

endmodule

[rtl/usv_cordic.sv]
// A group of CORDIC rotation steps in rotation mode.
// Depends on usv_pkg for the state type and the arctangent table.
module usv_cordic
  import usv_pkg::*;
#(
  parameter int FIRST = 0,
  parameter int NSTEP = 4
) (
  input  cord_t st_in,
  output cord_t st_out
);

  // Rotate toward zero residual angle; shifts are floor shifts.
  always_comb begin
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] nx;
    logic signed [33:0] z;
    logic signed [33:0] a;
    x = st_in.x;
    y = st_in.y;
    z = st_in.z;
    for (int s = 0; s < NSTEP; s++) begin
      a = $signed({2'b00, atan_turn(FIRST + s)});
      if (z >= 34'sd0) begin
        nx = x - (y >>> (FIRST + s));
        y  = y + (x >>> (FIRST + s));
        z  = z - a;
      end else begin
        nx = x + (y >>> (FIRST + s));
        y  = y - (x >>> (FIRST + s));
        z  = z + a;
      end
      x = nx;
    end
    st_out.x = x;
    st_out.y = y;
    st_out.z = z;
  end

endmodule

[rtl/uv_sphere_vertex_generator.sv]
// UV sphere vertex generator: top level with the full pipeline.
// Depends on usv_pkg, usv_div, usv_cordic and the assertion macro header.
//
// Usage: each input word carries a stack (row) and sector (column) index of
// one grid point; each output word carries the vertex index, position and
// normal in Q2.14, texture coordinates, the next row index and the two
// triangle flags for the cell whose top-left corner is this vertex.
// Counts are written on the cfg port (index 0 sector count, 1 stack count)
// while no words are in flight; a zero count acts as one.
// A word passes 14 register stages: one input stage, three divider stages
// of five quotient bits, one angle stage, six CORDIC stages of four
// rotations, a rounding stage, a multiply stage and the output register.
// Throughput is one word per cycle while the receiver does not stall; the
// chain of CORDIC rotations and restoring division steps sets the depth.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and in_tready drops; nothing is lost or repeated. Reset empties the
// pipeline and sets both counts to 64.
`include "uv_sphere_vertex_generator_defines.svh"
module uv_sphere_vertex_generator
  import usv_pkg::*;
#(
  parameter int MAX_SEGMENTS    = 1024,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [9:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // stack_index[9:0], sector_index[19:10], zero fill [23:20]
  input  logic [23:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // vertex_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s,
  // tex_t, next_row_index, upper_tri_valid, lower_tri_valid
  output logic [167:0] out_tdata
);

  localparam int B      = TRIG_TABLE_BITS;
  localparam int DIV_ST = 3;
  localparam int DIV_N  = 5;
  localparam int COR_ST = 6;
  localparam int COR_N  = CORDIC_STEPS / COR_ST;

  // Configuration registers.
  logic [9:0] sector_count_r, stack_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_count_r <= 10'd64;
      stack_count_r  <= 10'd64;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SECTOR_COUNT: sector_count_r <= cfg_wdata;
        REG_STACK_COUNT:  stack_count_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective counts: zero acts as one, large values clamp.
  function automatic logic [9:0] eff_count(input logic [9:0] v);
    logic [9:0] r;
    if (v == 10'd0) r = 10'd1;
    else if (32'(v) > 32'(MAX_SEGMENTS - 1)) r = 10'(MAX_SEGMENTS - 1);
    else r = v;
    return r;
  endfunction

  logic [9:0] sec_eff, stk_eff;
  assign sec_eff = eff_count(sector_count_r);
  assign stk_eff = eff_count(stack_count_r);

  // The whole pipeline advances unless a finished word is waiting.
  logic ce;
  assign ce = !out_tvalid || out_tready;
  assign in_tready = ce;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // Input stage: clamp indices and take the first quotient bit.
  logic [9:0] i_cl, j_cl;
  assign i_cl = (in_tdata[9:0]   > stk_eff) ? stk_eff : in_tdata[9:0];
  assign j_cl = (in_tdata[19:10] > sec_eff) ? sec_eff : in_tdata[19:10];

  logic [9:0]  i_r, j_r;
  logic [9:0]  dsec_r [DIV_ST+1];
  logic [9:0]  dstk_r [DIV_ST+1];
  logic [9:0]  remi_r [DIV_ST+1];
  logic [9:0]  remj_r [DIV_ST+1];
  logic [15:0] quoi_r [DIV_ST+1];
  logic [15:0] quoj_r [DIV_ST+1];
  meta_t       dmeta_r [DIV_ST+1];
  logic        dvld_r [DIV_ST+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r[0] <= 1'b0;
    end else if (ce) begin
      dvld_r[0] <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      i_r       <= i_cl;
      j_r       <= j_cl;
      dsec_r[0] <= sec_eff;
      dstk_r[0] <= stk_eff;
      remi_r[0] <= (i_cl >= stk_eff) ? 10'(i_cl - stk_eff) : i_cl;
      remj_r[0] <= (j_cl >= sec_eff) ? 10'(j_cl - sec_eff) : j_cl;
      quoi_r[0] <= {15'd0, i_cl >= stk_eff};
      quoj_r[0] <= {15'd0, j_cl >= sec_eff};
      dmeta_r[0] <= '0;
    end
  end

  // Vertex indices and triangle flags from the clamped indices.
  meta_t meta0;
  always_comb begin
    logic [10:0] sec1;
    logic [20:0] vfull;
    logic        is_cell;
    sec1    = {1'b0, dsec_r[0]} + 11'd1;
    vfull   = 21'(i_r) * 21'(sec1) + 21'(j_r);
    is_cell = (i_r < dstk_r[0]) && (j_r < dsec_r[0]);
    meta0.vidx  = vfull[19:0];
    meta0.nidx  = vfull[19:0] + 20'(sec1);
    meta0.tex_s = 15'd0;
    meta0.tex_t = 15'd0;
    meta0.up    = is_cell && (i_r != 10'd0);
    meta0.lo    = is_cell && (i_r != 10'(dstk_r[0] - 10'd1));
  end

  // Divider stages: i*2^15/stack and j*2^15/sector.
  for (genvar g = 0; g < DIV_ST; g++) begin : g_div
    logic [9:0]  ri, rj;
    logic [15:0] qi, qj;
    usv_div #(.NSTEP(DIV_N)) u_div_i (
      .den(dstk_r[g]), .rem_in(remi_r[g]), .quo_in(quoi_r[g]),
      .rem_out(ri), .quo_out(qi)
    );
    usv_div #(.NSTEP(DIV_N)) u_div_j (
      .den(dsec_r[g]), .rem_in(remj_r[g]), .quo_in(quoj_r[g]),
      .rem_out(rj), .quo_out(qj)
    );
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[g+1] <= 1'b0;
      end else if (ce) begin
        dvld_r[g+1] <= dvld_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        remi_r[g+1]  <= ri;
        remj_r[g+1]  <= rj;
        quoi_r[g+1]  <= qi;
        quoj_r[g+1]  <= qj;
        dsec_r[g+1]  <= dsec_r[g];
        dstk_r[g+1]  <= dstk_r[g];
        dmeta_r[g+1] <= (g == 0) ? meta0 : dmeta_r[g];
      end
    end
  end

  // Angle stage: round quotients to phases, quadrant fold, CORDIC seed.
  cord_t cst_t_r [COR_ST+1];
  cord_t cst_p_r [COR_ST+1];
  logic  flip_t_r [COR_ST+1];
  logic  flip_p_r [COR_ST+1];
  meta_t cmeta_r [COR_ST+1];
  logic  cvld_r [COR_ST+1];

  function automatic cord_t seed(input logic [B-1:0] ph, output logic flip);
    logic [31:0] ang;
    logic [31:0] a2;
    cord_t c;
    ang = {ph, {(32-B){1'b0}}};
    a2  = ang + 32'h4000_0000;
    flip = a2[31];
    if (a2[31]) ang = ang - 32'h8000_0000;
    c.x = CORDIC_GAIN_Q28;
    c.y = 32'sd0;
    c.z = 34'($signed(ang));
    return c;
  endfunction

  meta_t meta1;
  cord_t seed_t, seed_p;
  logic  fl_t, fl_p;
  always_comb begin
    logic [16:0] st, sp, tt, ts;
    st = {1'b0, quoi_r[DIV_ST] >> (15 - B)} + 17'd1;
    sp = {1'b0, quoj_r[DIV_ST] >> (14 - B)} + 17'd1;
    tt = {1'b0, quoi_r[DIV_ST]} + 17'd1;
    ts = {1'b0, quoj_r[DIV_ST]} + 17'd1;
    seed_t = seed(st[B:1], fl_t);
    seed_p = seed(sp[B:1], fl_p);
    meta1       = dmeta_r[DIV_ST];
    meta1.tex_t = tt[15:1];
    meta1.tex_s = ts[15:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r[0] <= 1'b0;
    end else if (ce) begin
      cvld_r[0] <= dvld_r[DIV_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cst_t_r[0]  <= seed_t;
      cst_p_r[0]  <= seed_p;
      flip_t_r[0] <= fl_t;
      flip_p_r[0] <= fl_p;
      cmeta_r[0]  <= meta1;
    end
  end

  // CORDIC stages for the polar and the azimuth angle.
  for (genvar g = 0; g < COR_ST; g++) begin : g_cor
    cord_t nt, np;
    usv_cordic #(.FIRST(g * COR_N), .NSTEP(COR_N)) u_cor_t (
      .st_in(cst_t_r[g]), .st_out(nt)
    );
    usv_cordic #(.FIRST(g * COR_N), .NSTEP(COR_N)) u_cor_p (
      .st_in(cst_p_r[g]), .st_out(np)
    );
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cvld_r[g+1] <= 1'b0;
      end else if (ce) begin
        cvld_r[g+1] <= cvld_r[g];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        cst_t_r[g+1]  <= nt;
        cst_p_r[g+1]  <= np;
        flip_t_r[g+1] <= flip_t_r[g];
        flip_p_r[g+1] <= flip_p_r[g];
        cmeta_r[g+1]  <= cmeta_r[g];
      end
    end
  end

  // Undo the fold, round to Q2.14 and clamp to plus or minus one.
  function automatic logic signed [15:0] to_q14(input logic signed [31:0] v,
                                                input logic neg);
    logic signed [31:0] f;
    logic signed [17:0] t;
    logic signed [15:0] r;
    f = neg ? -v : v;
    t = 18'((f + 32'sd8192) >>> 14);
    if (t > Q14_ONE) r = 16'sd16384;
    else if (t < -Q14_ONE) r = -16'sd16384;
    else r = t[15:0];
    return r;
  endfunction

  logic signed [15:0] sin_t_r, cos_t_r, sin_p_r, cos_p_r;
  meta_t rmeta_r;
  logic  rvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else if (ce) begin
      rvld_r <= cvld_r[COR_ST];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sin_t_r <= to_q14(cst_t_r[COR_ST].y, flip_t_r[COR_ST]);
      cos_t_r <= to_q14(cst_t_r[COR_ST].x, flip_t_r[COR_ST]);
      sin_p_r <= to_q14(cst_p_r[COR_ST].y, flip_p_r[COR_ST]);
      cos_p_r <= to_q14(cst_p_r[COR_ST].x, flip_p_r[COR_ST]);
      rmeta_r <= cmeta_r[COR_ST];
    end
  end

  // Multiply stage: sin(theta) times cos and sin of phi.
  logic signed [31:0] px_r, py_r;
  logic signed [15:0] mcos_t_r;
  meta_t mmeta_r;
  logic  mvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvld_r <= 1'b0;
    end else if (ce) begin
      mvld_r <= rvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      px_r     <= sin_t_r * cos_p_r;
      py_r     <= sin_t_r * sin_p_r;
      mcos_t_r <= cos_t_r;
      mmeta_r  <= rmeta_r;
    end
  end

  // Output register: scale products and pack the word.
  logic [167:0] odata_nxt;
  always_comb begin
    logic signed [31:0] pxp, pyp, pxn, pyn;
    logic signed [16:0] pz;
    pxp = (px_r + 32'sd16384) >>> 15;
    pyp = (py_r + 32'sd16384) >>> 15;
    pxn = (px_r + 32'sd8192) >>> 14;
    pyn = (py_r + 32'sd8192) >>> 14;
    pz  = (17'(mcos_t_r) + 17'sd1) >>> 1;
    odata_nxt = {mmeta_r.lo, mmeta_r.up, mmeta_r.nidx, mmeta_r.tex_t,
                 mmeta_r.tex_s, mcos_t_r, pyn[15:0], pxn[15:0], pz[15:0],
                 pyp[15:0], pxp[15:0], mmeta_r.vidx};
  end

  logic         out_tvalid_r;
  logic [167:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ce) begin
      out_tvalid_r <= mvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_tdata_r <= odata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Texture fields and the upper flag of the output word, for the checks.
  logic [14:0] out_tex_s, out_tex_t;
  logic        out_up;
  assign out_tex_s = out_tdata[130:116];
  assign out_tex_t = out_tdata[145:131];
  assign out_up    = out_tdata[166];

  // The pipeline comes out of reset empty.
  `USV_ASSERT_ALWAYS(a_reset_empty, $past(!rst_n) |-> !out_tvalid)
  // Texture coordinates never exceed one.
  `USV_ASSERT(a_tex_range, out_tvalid |-> (out_tex_s <= 15'd16384 && out_tex_t <= 15'd16384))
  // An upper triangle is never emitted on the first row.
  `USV_ASSERT(a_upper_not_top, (out_tvalid && out_up) |-> (out_tex_t != 15'd0))

endmodule
